[rtl/temp_sensor_block_average_assert.svh]
// Assertion macros shared by the temperature block averager RTL.
`ifndef TEMP_SENSOR_BLOCK_AVERAGE_ASSERT_SVH
`define TEMP_SENSOR_BLOCK_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TSBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tsba_pkg.sv]
// Types and constants of the temperature sensor block averager.
`default_nettype none
package tsba_pkg;

	localparam int SMP_W     = 12;
	localparam int REG_W     = 12;
	localparam int SUM_W     = 16;
	localparam int CNT_W     = 4;
	localparam int BLOCK_LEN = 10;

	// Rounded average is floor((2*sum + n) / (2*n)).
	localparam int AVG_DIVISOR = 2 * BLOCK_LEN;
	localparam int AVG_DVD_W   = SUM_W + 2;
	localparam int AVG_REM_W   = $clog2(AVG_DIVISOR);

	localparam int CEL_W  = 11;
	localparam int FAHR_W = 16;

	localparam int PROD_W  = 2 * REG_W;
	localparam int DIFF_W  = PROD_W + 1;
	localparam int DIFF5_W = DIFF_W + 3;
	localparam int ACC_W   = 38;
	localparam int QUO_W   = CEL_W;
	localparam int STEP_W  = $clog2(AVG_DVD_W);

	// 2*(25 + 1024) + 1: rounding bias, the 25 degree offset and the
	// 1024 shift that keeps the quotient non-negative, all in units of pd.
	localparam logic [REG_W-1:0] CAL_SCALE = REG_W'(2099);

	localparam logic signed [FAHR_W-1:0] FAHR_OFFSET = 16'sd320;

	localparam logic [REG_W-1:0] CAL30_RST  = 12'd940;
	localparam logic [REG_W-1:0] CAL110_RST = 12'd1220;
	localparam logic [REG_W-1:0] V25_RST    = 12'd760;
	localparam logic [REG_W-1:0] REFMV_RST  = 12'd3300;

	typedef enum logic [1:0] {
		REG_CAL30,
		REG_CAL110,
		REG_V25,
		REG_REF
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_MUL,
		ST_DIFF,
		ST_CONST,
		ST_SUM,
		ST_CHK,
		ST_DIV,
		ST_FAHR,
		ST_DONE
	} tsba_state_t;

endpackage
`default_nettype wire

[rtl/temp_sensor_block_average.sv]
// Block averager with exact calibrated temperature conversion.
//
//  channel | direction | handshake           | words
//  in      | input     | in_valid / in_stall  | sample
//  out     | output    | out_valid / out_stall| average_raw, celsius, fahrenheit_tenths, cal_error
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// Samples that do not close a block are accepted back to back while the block is idle.
// The sample that closes a block starts a sequence set by the bit-serial average divide,
// the serial multiply, the constant scale, the restoring temperature divide and five single
// steps (some skipped on saturation or a calibration error); in_stall is high throughout.
// arst_n clears the sum, the count, the sequencer and the output valid.
// A stalled output word is held; the next block is accepted while it waits and
// its result waits in the final step until the output register is free.
`default_nettype none
`include "temp_sensor_block_average_assert.svh"
module temp_sensor_block_average (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [1:0]                             cfg_index,
	input  wire logic [tsba_pkg::REG_W-1:0]             cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [tsba_pkg::SMP_W-1:0]             sample,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [tsba_pkg::SMP_W-1:0]                  average_raw,
	output logic signed [tsba_pkg::CEL_W-1:0]           celsius,
	output logic signed [tsba_pkg::FAHR_W-1:0]          fahrenheit_tenths,
	output logic                                        cal_error
);
	import tsba_pkg::*;

	tsba_state_t state_q, state_next;

	logic [REG_W-1:0] cal30_q, cal110_q, v25_q, refmv_q;

	logic [SUM_W-1:0] sum_q, sum_next;
	logic [CNT_W-1:0] count_q;
	logic             block_end;
	logic [STEP_W-1:0] step_q;
	logic             step_last;

	logic [AVG_DVD_W-1:0] avg_dvd_q, avg_quo_q;
	logic [AVG_REM_W-1:0] avg_rem_q;
	logic [AVG_REM_W:0]   avg_rem_sh;
	logic                 avg_ge;
	logic [SMP_W-1:0]     avg_sat;

	logic              cal_neg, cal_eq;
	logic [REG_W-1:0]  cal_mag, ref_eff;
	logic              err_q;

	logic [REG_W-1:0]  ref_sh_q, scale_sh_q;
	logic [PROD_W-1:0] pa_q, pd_q;

	logic signed [DIFF_W-1:0]  v25_scaled, pa_signed, diff_q;
	logic signed [DIFF5_W-1:0] diff_ext, diff5_q;
	logic signed [ACC_W-1:0]   acc_q, diff5_ext;
	logic [ACC_W-1:0]          pd_ext, sat_limit;

	logic [ACC_W-1:0] rem_q, dsor_q;
	logic             div_ge;
	logic [QUO_W-1:0] qt_q;

	logic signed [CEL_W-1:0]  cel;
	logic signed [FAHR_W-1:0] cel_ext, f_q;

	logic                     out_valid_q, out_load, in_take;
	logic [SMP_W-1:0]         average_q;
	logic signed [CEL_W-1:0]  celsius_q;
	logic signed [FAHR_W-1:0] fahr_q;
	logic                     cal_error_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal30_q  <= CAL30_RST;
			cal110_q <= CAL110_RST;
			v25_q    <= V25_RST;
			refmv_q  <= REFMV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL30:  cal30_q  <= cfg_data;
				REG_CAL110: cal110_q <= cfg_data;
				REG_V25:    v25_q    <= cfg_data;
				REG_REF:    refmv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath combinational terms
	always_comb begin
		sum_next  = sum_q + SUM_W'(sample);
		block_end = (count_q == CNT_W'(BLOCK_LEN - 1));
		step_last = (step_q == '0);

		avg_rem_sh = {avg_rem_q, avg_dvd_q[AVG_DVD_W-1]};
		avg_ge     = (avg_rem_sh >= (AVG_REM_W + 1)'(AVG_DIVISOR));
		avg_sat    = (|avg_quo_q[AVG_DVD_W-1:SMP_W]) ? '1 : avg_quo_q[SMP_W-1:0];

		cal_neg = (cal30_q < cal110_q);
		cal_eq  = (cal30_q == cal110_q);
		cal_mag = cal_neg ? (cal110_q - cal30_q) : (cal30_q - cal110_q);
		ref_eff = (refmv_q == '0) ? REG_W'(1) : refmv_q;

		v25_scaled = signed'({1'b0, v25_q, {SMP_W{1'b0}}});
		pa_signed  = signed'({1'b0, pa_q});
		diff_ext   = DIFF5_W'(diff_q);
		diff5_ext  = ACC_W'(diff5_q);
		pd_ext     = ACC_W'(pd_q);
		sat_limit  = ACC_W'({pd_q, {(QUO_W + 1){1'b0}}});

		div_ge  = (rem_q >= dsor_q);
		cel     = signed'({~qt_q[QUO_W-1], qt_q[QUO_W-2:0]});
		cel_ext = FAHR_W'(cel);
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:  if (in_take && block_end) state_next = ST_AVG;
			ST_AVG:   if (step_last) state_next = cal_eq ? ST_DONE : ST_MUL;
			ST_MUL:   if (step_last) state_next = ST_DIFF;
			ST_DIFF:  state_next = ST_CONST;
			ST_CONST: if (step_last) state_next = ST_SUM;
			ST_SUM:   state_next = ST_CHK;
			ST_CHK: begin
				if (acc_q[ACC_W-1] || ($unsigned(acc_q) >= sat_limit))
					state_next = ST_FAHR;
				else
					state_next = ST_DIV;
			end
			ST_DIV:   if (step_last) state_next = ST_FAHR;
			ST_FAHR:  state_next = ST_DONE;
			ST_DONE:  if (out_load) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		in_take  = in_valid && (state_q == ST_IDLE);
		out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (in_take) begin
				if (block_end) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				avg_dvd_q <= {1'b0, sum_next, 1'b0} + AVG_DVD_W'(BLOCK_LEN);
				avg_rem_q <= '0;
				step_q    <= STEP_W'(AVG_DVD_W - 1);
			end
			ST_AVG: begin
				// Shift one dividend bit into the remainder per cycle
				avg_dvd_q <= {avg_dvd_q[AVG_DVD_W-2:0], 1'b0};
				avg_rem_q <= avg_ge ? AVG_REM_W'(avg_rem_sh - (AVG_REM_W + 1)'(AVG_DIVISOR))
				                    : AVG_REM_W'(avg_rem_sh);
				avg_quo_q <= {avg_quo_q[AVG_DVD_W-2:0], avg_ge};
				err_q     <= cal_eq;
				ref_sh_q  <= ref_eff;
				pa_q      <= '0;
				pd_q      <= '0;
				if (step_last)
					step_q <= STEP_W'(REG_W - 1);
				else
					step_q <= step_q - STEP_W'(1);
			end
			ST_MUL: begin
				// Both products share the reference multiplier bits, MSB first
				pa_q     <= {pa_q[PROD_W-2:0], 1'b0} +
				            (ref_sh_q[REG_W-1] ? PROD_W'(avg_sat) : '0);
				pd_q     <= {pd_q[PROD_W-2:0], 1'b0} +
				            (ref_sh_q[REG_W-1] ? PROD_W'(cal_mag) : '0);
				ref_sh_q <= {ref_sh_q[REG_W-2:0], 1'b0};
				step_q   <= step_q - STEP_W'(1);
			end
			ST_DIFF: begin
				// Fold the denominator sign into the numerator
				diff_q     <= cal_neg ? (pa_signed - v25_scaled) : (v25_scaled - pa_signed);
				acc_q      <= '0;
				scale_sh_q <= CAL_SCALE;
				step_q     <= STEP_W'(REG_W - 1);
			end
			ST_CONST: begin
				acc_q      <= signed'(($unsigned(acc_q) << 1) +
				              (scale_sh_q[REG_W-1] ? pd_ext : '0));
				scale_sh_q <= {scale_sh_q[REG_W-2:0], 1'b0};
				diff5_q    <= (diff_ext <<< 2) + diff_ext;
				step_q     <= step_q - STEP_W'(1);
			end
			ST_SUM: begin
				// Add 160 * diff, twice the scaled numerator
				acc_q <= acc_q + (diff5_ext <<< 5);
			end
			ST_CHK: begin
				rem_q  <= $unsigned(acc_q);
				dsor_q <= ACC_W'({pd_q, {QUO_W{1'b0}}});
				step_q <= STEP_W'(QUO_W - 1);
				if (acc_q[ACC_W-1])
					qt_q <= '0;
				else
					qt_q <= '1;
			end
			ST_DIV: begin
				rem_q  <= div_ge ? (rem_q - dsor_q) : rem_q;
				dsor_q <= dsor_q >> 1;
				qt_q   <= {qt_q[QUO_W-2:0], div_ge};
				step_q <= step_q - STEP_W'(1);
			end
			ST_FAHR: begin
				f_q <= (cel_ext <<< 4) + (cel_ext <<< 1);
			end
			ST_DONE: begin
				if (out_load) begin
					average_q   <= avg_sat;
					cal_error_q <= err_q;
					celsius_q   <= err_q ? '0 : cel;
					fahr_q      <= err_q ? '0 : (f_q + FAHR_OFFSET);
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign average_raw       = average_q;
	assign celsius           = celsius_q;
	assign fahrenheit_tenths = fahr_q;
	assign cal_error         = cal_error_q;

	`TSBA_ASSERT_NEXT(a_block_starts, (in_take && block_end), (state_q == ST_AVG && count_q == '0), "block end did not start the conversion")
	`TSBA_ASSERT_NEXT(a_result_posted, out_load, out_valid_q, "finished result not posted")
	`TSBA_ASSERT_NOW(a_err_zero, (out_valid_q && cal_error_q), (celsius_q == '0 && fahr_q == '0), "calibration error with nonzero temperature")
	`TSBA_ASSERT_NOW(a_fahr_match, (out_valid_q && !cal_error_q), (fahr_q == celsius_q * 16'sd18 + FAHR_OFFSET), "fahrenheit does not follow celsius")

endmodule
`default_nettype wire

[sim/temp_sensor_block_average_test.sv]
// Self-checking testbench for the temperature sensor block averager.
`timescale 1ns / 1ps
module temp_sensor_block_average_test;
	import tsba_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 80;
	localparam int LONG_HOLD = 300;
	localparam int REPORT_LIMIT = 10;
	localparam int TIMEOUT_NS = 2_000_000;

	typedef struct packed {
		logic [SMP_W-1:0] avg;
		logic signed [CEL_W-1:0] cel;
		logic signed [FAHR_W-1:0] fahr;
		logic err;
	} temp_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_CAL30;
	logic [REG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SMP_W-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SMP_W-1:0] average_raw;
	logic signed [CEL_W-1:0] celsius;
	logic signed [FAHR_W-1:0] fahrenheit_tenths;
	logic cal_error;

	// predictor state and shadow registers
	logic [REG_W-1:0] cal30_shadow = CAL30_RST;
	logic [REG_W-1:0] cal110_shadow = CAL110_RST;
	logic [REG_W-1:0] v25_shadow = V25_RST;
	logic [REG_W-1:0] refmv_shadow = REFMV_RST;
	logic [SUM_W-1:0] block_sum = '0;
	int block_fill = 0;
	temp_result_t expected_temps[$];

	int mismatch_count = 0;
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;

	temp_sensor_block_average i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.average_raw(average_raw),
		.celsius(celsius),
		.fahrenheit_tenths(fahrenheit_tenths),
		.cal_error(cal_error)
	);

	always #HALF_PERIOD clk = ~clk;

	// Accumulate one accepted sample; on a closing sample queue the temperature word.
	function automatic void accumulate_sample(input logic [SMP_W-1:0] v);
		longint avg, refmv, num, den, cel;
		temp_result_t r;
		block_sum = SUM_W'(block_sum + v);
		if (block_fill + 1 < BLOCK_LEN) begin
			block_fill++;
			return;
		end
		avg = (2 * longint'(block_sum) + BLOCK_LEN) / (2 * BLOCK_LEN);
		if (avg > 4095)
			avg = 4095;
		block_sum = '0;
		block_fill = 0;
		r = '0;
		r.avg = avg[SMP_W-1:0];
		if (cal30_shadow == cal110_shadow) begin
			r.err = 1'b1;
		end else begin
			refmv = (refmv_shadow == 0) ? 1 : longint'(refmv_shadow);
			num = (longint'(v25_shadow) * 4096 - avg * refmv) * 80;
			den = refmv * (longint'(cal30_shadow) - longint'(cal110_shadow));
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			// floor(num/den + 25 + 1/2), flooring toward minus infinity
			num = 2 * num + 51 * den;
			den = 2 * den;
			cel = num / den;
			if (num % den != 0 && num < 0)
				cel--;
			if (cel < -1024)
				cel = -1024;
			if (cel > 1023)
				cel = 1023;
			r.cel = cel[CEL_W-1:0];
			r.fahr = FAHR_W'(cel * 18 + 320);
		end
		expected_temps.push_back(r);
	endfunction

	// Offer one sample word and hold it until accepted.
	task automatic send_sample(input logic [SMP_W-1:0] v);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (in_stall);
		accumulate_sample(v);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
	endtask

	// Wait until the block is idle, then write all four registers.
	task automatic set_config(input logic [REG_W-1:0] c30, input logic [REG_W-1:0] c110,
			input logic [REG_W-1:0] v25, input logic [REG_W-1:0] refmv);
		while (expected_temps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_CAL30;
		cfg_data <= c30;
		@(posedge clk);
		cfg_index <= REG_CAL110;
		cfg_data <= c110;
		@(posedge clk);
		cfg_index <= REG_V25;
		cfg_data <= v25;
		@(posedge clk);
		cfg_index <= REG_REF;
		cfg_data <= refmv;
		@(posedge clk);
		cfg_we <= 1'b0;
		cal30_shadow = c30;
		cal110_shadow = c110;
		v25_shadow = v25;
		refmv_shadow = refmv;
	endtask

	// Random samples: mostly clustered around a level, some anywhere.
	task automatic send_random_samples(input int count);
		int level;
		level = $urandom_range(0, 4095);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_sample(SMP_W'($urandom_range(0, 4095)));
			else
				send_sample(SMP_W'(level + $urandom_range(0, 64) - 32));
		end
		end_burst();
	endtask

	task automatic test_sample_extremes();
		for (int i = 0; i < BLOCK_LEN; i++)
			send_sample('0);
		for (int i = 0; i < BLOCK_LEN; i++)
			send_sample('1);
		end_burst();
	endtask

	task automatic test_config_sweep();
		logic [REG_W-1:0] c30, c110;
		// equal calibration, both extreme spans, saturation, zero reference
		set_config(12'd500, 12'd500, 12'd760, 12'd3300);
		send_random_samples(3 * BLOCK_LEN + $urandom_range(0, BLOCK_LEN - 1));
		set_config(12'd0, 12'd4095, 12'd4095, 12'd1);
		send_random_samples(3 * BLOCK_LEN + $urandom_range(0, BLOCK_LEN - 1));
		set_config(12'd4095, 12'd0, 12'd4095, 12'd1);
		send_random_samples(3 * BLOCK_LEN + $urandom_range(0, BLOCK_LEN - 1));
		set_config(12'd4095, 12'd0, 12'd0, 12'd4095);
		send_random_samples(3 * BLOCK_LEN + $urandom_range(0, BLOCK_LEN - 1));
		set_config(12'd940, 12'd1220, 12'd760, 12'd0);
		send_random_samples(3 * BLOCK_LEN + $urandom_range(0, BLOCK_LEN - 1));
		for (int p = 0; p < 5; p++) begin
			c30 = REG_W'($urandom_range(0, 4095));
			// small spans push the result to saturation and tight rounding
			if ($urandom_range(0, 1) == 0)
				c110 = REG_W'(c30 + $urandom_range(0, 6) - 3);
			else
				c110 = REG_W'($urandom_range(0, 4095));
			set_config(c30, c110, REG_W'($urandom_range(0, 4095)),
				REG_W'($urandom_range(0, 4095)));
			send_random_samples(3 * BLOCK_LEN + $urandom_range(0, BLOCK_LEN - 1));
		end
	endtask

	// Receiver holds off while samples keep coming, so the block backs up.
	task automatic test_long_hold();
		set_config(12'd940, 12'd1220, 12'd760, 12'd3300);
		hold_request = 1'b1;
		send_random_samples(4 * BLOCK_LEN);
	endtask

	task automatic test_full_rate();
		set_config(REG_W'($urandom_range(0, 4095)), REG_W'($urandom_range(0, 4095)),
			REG_W'($urandom_range(0, 4095)), REG_W'($urandom_range(1, 4095)));
		idle_on = 1'b0;
		send_random_samples(5 * BLOCK_LEN);
	endtask

	// receiver stall: random short bursts, or one long hold on request
	initial begin
		int burst_left;
		int hold_left;
		burst_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare each accepted output word with the oldest expected one
	always @(posedge clk) begin
		temp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_temps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected word: avg %0d cel %0d fahr %0d err %0b",
						average_raw, celsius, fahrenheit_tenths, cal_error);
			end else begin
				want = expected_temps.pop_front();
				if (average_raw !== want.avg || celsius !== want.cel
						|| fahrenheit_tenths !== want.fahr || cal_error !== want.err) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: expected avg %0d cel %0d fahr %0d err %0b, got avg %0d cel %0d fahr %0d err %0b",
							want.avg, want.cel, want.fahr, want.err,
							average_raw, celsius, fahrenheit_tenths, cal_error);
				end
			end
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sample_extremes();
		test_config_sweep();
		test_long_hold();
		test_full_rate();
		while (expected_temps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_temps.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[temp_sensor_block_average.f]
+incdir+rtl
rtl/tsba_pkg.sv
rtl/temp_sensor_block_average.sv
sim/temp_sensor_block_average_test.sv
